### rtl/core/oversampled_pad_frame_decoder_core_macros.svh
// Assertion helpers for the pad frame decoder.
`ifndef OVERSAMPLED_PAD_FRAME_DECODER_CORE_MACROS_SVH
`define OVERSAMPLED_PAD_FRAME_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define OPFD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define OPFD_ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define OPFD_ASSERT(label, clk, rst_n, prop)
`define OPFD_ASSERT_NEVER(label, clk, rst_n, prop)
`endif

`endif

### rtl/core/opfd_pkg.sv
`timescale 1ns / 1ps

package opfd_pkg;

  typedef enum logic [1:0] {
    CfgEdgeSearchLimit = 2'd0,
    CfgRunLimit        = 2'd1,
    CfgLineSelect      = 2'd2
  } cfg_index_e;

  localparam logic [7:0] EdgeSearchLimitRst = 8'd32;
  localparam logic [3:0] RunLimitRst        = 4'd8;
  localparam logic [2:0] LineSelectRst      = 3'd0;

  localparam logic [6:0] LastBit = 7'd63;

  typedef struct packed {
    logic [7:0] edge_search_limit;
    logic [3:0] run_limit;
    logic [2:0] line_select;
  } cfg_t;

  typedef struct packed {
    logic level;
    logic start;
  } item_t;

  typedef struct packed {
    logic [15:0] buttons;
    logic [7:0]  stick_x;
    logic [7:0]  stick_y;
    logic [7:0]  cstick_x;
    logic [7:0]  cstick_y;
    logic [7:0]  left_trigger;
    logic [7:0]  right_trigger;
    logic        frame_failed;
  } result_t;

  function automatic logic [7:0] rev_byte(logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = b[7-i];
    end
    return r;
  endfunction

  // bits[i] holds received bit i
  function automatic result_t pack_frame(logic [63:0] bits);
    result_t r;
    r.buttons       = bits[15:0];
    r.stick_x       = rev_byte(bits[23:16]);
    r.stick_y       = rev_byte(bits[31:24]);
    r.cstick_x      = rev_byte(bits[39:32]);
    r.cstick_y      = rev_byte(bits[47:40]);
    r.left_trigger  = rev_byte(bits[55:48]);
    r.right_trigger = rev_byte(bits[63:56]);
    r.frame_failed  = 1'b0;
    return r;
  endfunction

endpackage

### rtl/core/opfd_front.sv
`timescale 1ns / 1ps

// Picks the line level out of each sample and queues it for the decoder.
module opfd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  opfd_pkg::cfg_t     cfg_i,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         sample_byte_i,
  input  logic               frame_start_i,
  output logic               item_valid_o,
  output opfd_pkg::item_t    item_o,
  input  logic               item_pop_i
);

  opfd_pkg::item_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            do_push, do_pop;
  opfd_pkg::item_t new_item;

  assign full         = (count_q == 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];

  assign do_push = push && !full;
  assign do_pop  = item_pop_i && item_valid_o;

  always_comb begin
    new_item.level = sample_byte_i[cfg_i.line_select];
    new_item.start = frame_start_i;
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

### rtl/core/opfd_back.sv
`timescale 1ns / 1ps

// Frame decoder: edge search, low/high run timing, bit assembly.
module opfd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  opfd_pkg::cfg_t     cfg_i,
  input  logic               item_valid_i,
  input  opfd_pkg::item_t    item_i,
  output logic               item_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output opfd_pkg::result_t  res_o
);

  typedef enum logic [1:0] {
    PhIdle,
    PhSeek,
    PhLow,
    PhHigh
  } phase_e;

  phase_e      phase_q, phase_d, cur_phase;
  logic [7:0]  seek_q, seek_d, cur_seek;
  logic [4:0]  low_q, low_d, cur_low;
  logic [4:0]  high_q, high_d, cur_high;
  logic [6:0]  bit_cnt_q, bit_cnt_d, cur_bit_cnt;
  logic [63:0] bits_q, bits_d;
  logic [8:0]  seek_inc, seek_lim;
  logic [4:0]  run_cap;
  logic        take, new_bit;
  opfd_pkg::result_t fail_res;

  assign take       = item_valid_i && !res_full_i;
  assign item_pop_o = take;

  always_comb begin
    fail_res              = '0;
    fail_res.frame_failed = 1'b1;
    seek_lim = (cfg_i.edge_search_limit == 8'd0) ? 9'd256 : {1'b0, cfg_i.edge_search_limit};
    run_cap  = (cfg_i.run_limit == 4'd0) ? 5'd16 : {1'b0, cfg_i.run_limit};

    cur_phase   = phase_q;
    cur_seek    = seek_q;
    cur_low     = low_q;
    cur_high    = high_q;
    cur_bit_cnt = bit_cnt_q;
    if (item_i.start) begin
      cur_phase   = PhSeek;
      cur_seek    = 8'd0;
      cur_low     = 5'd0;
      cur_high    = 5'd0;
      cur_bit_cnt = 7'd0;
    end
    seek_inc = {1'b0, cur_seek} + 9'd1;
    new_bit  = (cur_high >= cur_low);

    phase_d    = phase_q;
    seek_d     = seek_q;
    low_d      = low_q;
    high_d     = high_q;
    bit_cnt_d  = bit_cnt_q;
    bits_d     = bits_q;
    res_push_o = 1'b0;
    res_o      = fail_res;

    if (take) begin
      phase_d   = cur_phase;
      seek_d    = cur_seek;
      low_d     = cur_low;
      high_d    = cur_high;
      bit_cnt_d = cur_bit_cnt;
      unique case (cur_phase)
        PhSeek: begin
          if (item_i.level) begin
            if (seek_inc >= seek_lim) begin
              phase_d    = PhIdle;
              res_push_o = 1'b1;
            end else begin
              seek_d = seek_inc[7:0];
            end
          end else begin
            low_d   = 5'd1;
            high_d  = 5'd0;
            phase_d = PhLow;
          end
        end
        PhLow: begin
          if (!item_i.level) begin
            low_d = cur_low + 5'd1;
            if (cur_low >= run_cap) begin
              phase_d    = PhIdle;
              res_push_o = 1'b1;
            end
          end else begin
            high_d  = 5'd1;
            phase_d = PhHigh;
          end
        end
        PhHigh: begin
          if (item_i.level) begin
            high_d = cur_high + 5'd1;
            if (cur_high >= run_cap) begin
              phase_d    = PhIdle;
              res_push_o = 1'b1;
            end
          end else begin
            // bits enter at the top; after 64 of them bit i sits at index i
            bits_d    = {new_bit, bits_q[63:1]};
            bit_cnt_d = cur_bit_cnt + 7'd1;
            low_d     = 5'd1;
            high_d    = 5'd0;
            phase_d   = PhLow;
            if (cur_bit_cnt == opfd_pkg::LastBit) begin
              phase_d    = PhIdle;
              res_push_o = 1'b1;
              res_o      = opfd_pkg::pack_frame(bits_d);
            end
          end
        end
        default: begin
          phase_d = cur_phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      seek_q    <= 8'd0;
      low_q     <= 5'd0;
      high_q    <= 5'd0;
      bit_cnt_q <= 7'd0;
    end else begin
      phase_q   <= phase_d;
      seek_q    <= seek_d;
      low_q     <= low_d;
      high_q    <= high_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q <= bits_d;
  end

endmodule

### rtl/core/opfd_resq.sv
`timescale 1ns / 1ps

// Two-entry result queue toward the consumer.
module opfd_resq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               res_push_i,
  input  opfd_pkg::result_t  res_i,
  output logic               res_full_o,
  input  logic               pop,
  output logic               empty,
  output opfd_pkg::result_t  res_o
);

  opfd_pkg::result_t mem_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;
  logic              do_push, do_pop;

  assign res_full_o = (count_q == 2'd2);
  assign empty      = (count_q == 2'd0);
  assign res_o      = mem_q[rd_ptr_q];

  assign do_push = res_push_i && !res_full_o;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

### rtl/core/oversampled_pad_frame_decoder_core.sv
`timescale 1ns / 1ps

// Oversampled pad frame decoder.
// Input side is a queue: drive sample_byte_i/frame_start_i and raise push;
// a transaction happens on a clock edge with push high and full low.
// frame_start_i restarts the decoder on that same sample. One result per
// frame comes out of the result queue: while empty is low the ports show the
// oldest result, taken on an edge with pop high. Failed frames give
// frame_failed_o = 1 with zero data.
// Throughput: one sample per clock while the result queue has room; the decoder
// updates counters and a shift register once per sample. A result reaches the
// result ports through the input queue, which takes the sample that ended the
// frame, and then the result queue, which the decoder writes when it takes that
// sample. Configuration writes (cfg_valid_i/cfg_ready_o, always ready) must be
// made only while no transaction is in flight; the block does not enforce this.
// Reset empties both queues, idles the decoder and loads the register defaults.
// If the consumer stalls, the result queue and then the input queue fill, and
// full holds off further samples.
`include "oversampled_pad_frame_decoder_core_macros.svh"

module oversampled_pad_frame_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  sample_byte_i,
  input  logic        frame_start_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] buttons_o,
  output logic [7:0]  stick_x_o,
  output logic [7:0]  stick_y_o,
  output logic [7:0]  cstick_x_o,
  output logic [7:0]  cstick_y_o,
  output logic [7:0]  left_trigger_o,
  output logic [7:0]  right_trigger_o,
  output logic        frame_failed_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  opfd_pkg::cfg_t    cfg_q, cfg_d;
  logic              item_valid, item_pop;
  opfd_pkg::item_t   item;
  logic              res_push, res_full;
  opfd_pkg::result_t res_in, res_out;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        opfd_pkg::CfgEdgeSearchLimit: cfg_d.edge_search_limit = cfg_data_i;
        opfd_pkg::CfgRunLimit:        cfg_d.run_limit         = cfg_data_i[3:0];
        opfd_pkg::CfgLineSelect:      cfg_d.line_select       = cfg_data_i[2:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.edge_search_limit <= opfd_pkg::EdgeSearchLimitRst;
      cfg_q.run_limit         <= opfd_pkg::RunLimitRst;
      cfg_q.line_select       <= opfd_pkg::LineSelectRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  opfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .push          (push),
    .full          (full),
    .sample_byte_i (sample_byte_i),
    .frame_start_i (frame_start_i),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  opfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  opfd_resq u_resq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res_out)
  );

  assign buttons_o       = res_out.buttons;
  assign stick_x_o       = res_out.stick_x;
  assign stick_y_o       = res_out.stick_y;
  assign cstick_x_o      = res_out.cstick_x;
  assign cstick_y_o      = res_out.cstick_y;
  assign left_trigger_o  = res_out.left_trigger;
  assign right_trigger_o = res_out.right_trigger;
  assign frame_failed_o  = res_out.frame_failed;

  `OPFD_ASSERT(a_fail_zero, clk_i, rst_ni, (!empty && frame_failed_o) |-> (res_out[64:1] == '0))
  `OPFD_ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, res_push && res_full)
  `OPFD_ASSERT_NEVER(a_no_pop_when_idle, clk_i, rst_ni, item_pop && !item_valid)

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import opfd_pkg::*;

  typedef enum logic [1:0] {PhIdle, PhSeek, PhLow, PhHigh} dec_phase_e;
  typedef enum int {FrmGood, FrmLongRun, FrmLongSeek, FrmCut} frame_kind_e;

  class frame_decode_tracker;
    cfg_t        cfg = '{EdgeSearchLimitRst, RunLimitRst, LineSelectRst};
    dec_phase_e  phase = PhIdle;
    logic [7:0]  seek_cnt = '0;
    logic [4:0]  low_cnt = '0;
    logic [4:0]  high_cnt = '0;
    logic [6:0]  bit_cnt = '0;
    logic [63:0] frame_bits = '0;
    result_t     pending_reports[$];
    int          errors = 0;
    int          n_decoded = 0;
    int          n_failed = 0;

    function int pending();
      return pending_reports.size();
    endfunction

    function int edge_lim();
      return (cfg.edge_search_limit == 0) ? 256 : int'(cfg.edge_search_limit);
    endfunction

    function int run_cap();
      return (cfg.run_limit == 0) ? 16 : int'(cfg.run_limit);
    endfunction

    function void set_reg(cfg_index_e idx, logic [7:0] val);
      case (idx)
        CfgEdgeSearchLimit: cfg.edge_search_limit = val;
        CfgRunLimit:        cfg.run_limit = val[3:0];
        CfgLineSelect:      cfg.line_select = val[2:0];
        default: ;
      endcase
    endfunction

    function void report_failure();
      result_t r;
      r = '0;
      r.frame_failed = 1'b1;
      pending_reports.push_back(r);
      phase = PhIdle;
      n_failed++;
    endfunction

    function void report_frame();
      result_t    r;
      logic [7:0] fb [6];
      for (int k = 0; k < 6; k++) begin
        for (int j = 0; j < 8; j++) begin
          fb[k][7-j] = frame_bits[16 + 8*k + j];
        end
      end
      r.buttons       = frame_bits[15:0];
      r.stick_x       = fb[0];
      r.stick_y       = fb[1];
      r.cstick_x      = fb[2];
      r.cstick_y      = fb[3];
      r.left_trigger  = fb[4];
      r.right_trigger = fb[5];
      r.frame_failed  = 1'b0;
      pending_reports.push_back(r);
      phase = PhIdle;
      n_decoded++;
    endfunction

    function void take_sample(logic [7:0] b, logic st);
      logic lvl;
      lvl = b[cfg.line_select];
      if (st) begin
        phase      = PhSeek;
        seek_cnt   = '0;
        low_cnt    = '0;
        high_cnt   = '0;
        bit_cnt    = '0;
        frame_bits = '0;
      end
      case (phase)
        PhSeek: begin
          if (lvl) begin
            if (int'(seek_cnt) + 1 >= edge_lim()) report_failure();
            else seek_cnt = seek_cnt + 8'd1;
          end else begin
            low_cnt  = 5'd1;
            high_cnt = 5'd0;
            phase    = PhLow;
          end
        end
        PhLow: begin
          if (!lvl) begin
            low_cnt = low_cnt + 5'd1;
            if (int'(low_cnt) - 1 >= run_cap()) report_failure();
          end else begin
            high_cnt = 5'd1;
            phase    = PhHigh;
          end
        end
        PhHigh: begin
          if (lvl) begin
            high_cnt = high_cnt + 5'd1;
            if (int'(high_cnt) - 1 >= run_cap()) report_failure();
          end else begin
            if (high_cnt >= low_cnt) frame_bits[bit_cnt[5:0]] = 1'b1;
            bit_cnt = bit_cnt + 7'd1;
            if (bit_cnt >= 64) begin
              report_frame();
            end else begin
              low_cnt  = 5'd1;
              high_cnt = 5'd0;
              phase    = PhLow;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void cmp_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %h, got %h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_report(result_t got);
      result_t exp_r;
      if (pending_reports.size() == 0) begin
        $error("unexpected result transaction: buttons %h failed %b",
               got.buttons, got.frame_failed);
        errors++;
        return;
      end
      exp_r = pending_reports.pop_front();
      cmp_field("buttons", exp_r.buttons, got.buttons);
      cmp_field("stick_x", exp_r.stick_x, got.stick_x);
      cmp_field("stick_y", exp_r.stick_y, got.stick_y);
      cmp_field("cstick_x", exp_r.cstick_x, got.cstick_x);
      cmp_field("cstick_y", exp_r.cstick_y, got.cstick_y);
      cmp_field("left_trigger", exp_r.left_trigger, got.left_trigger);
      cmp_field("right_trigger", exp_r.right_trigger, got.right_trigger);
      cmp_field("frame_failed", exp_r.frame_failed, got.frame_failed);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  sample_byte_i;
  logic        frame_start_i;
  logic        empty;
  logic        pop;
  logic [15:0] buttons_o;
  logic [7:0]  stick_x_o;
  logic [7:0]  stick_y_o;
  logic [7:0]  cstick_x_o;
  logic [7:0]  cstick_y_o;
  logic [7:0]  left_trigger_o;
  logic [7:0]  right_trigger_o;
  logic        frame_failed_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  frame_decode_tracker sb;
  bit steady = 0;
  bit hold_off_req = 0;
  int n_samples = 0;
  int n_settings = 0;
  int stall_cycles = 0;

  oversampled_pad_frame_decoder_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .sample_byte_i  (sample_byte_i),
    .frame_start_i  (frame_start_i),
    .empty          (empty),
    .pop            (pop),
    .buttons_o      (buttons_o),
    .stick_x_o      (stick_x_o),
    .stick_y_o      (stick_y_o),
    .cstick_x_o     (cstick_x_o),
    .cstick_y_o     (cstick_y_o),
    .left_trigger_o (left_trigger_o),
    .right_trigger_o(right_trigger_o),
    .frame_failed_o (frame_failed_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic send_sample(logic [7:0] b, logic st);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    sample_byte_i <= b;
    frame_start_i <= st;
    do begin
      @(posedge clk_i);
      if (full) stall_cycles++;
    end while (full);
    sb.take_sample(b, st);
    n_samples++;
  endtask

  task automatic send_level(logic lvl, logic st);
    logic [7:0] b;
    b = 8'($urandom);
    b[sb.cfg.line_select] = lvl;
    send_sample(b, st);
  endtask

  // wait for all results, then let in-flight samples drain
  task automatic settle();
    int guard;
    guard = 0;
    push <= 1'b0;
    while (sb.pending() != 0 && guard < 50000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (16) @(posedge clk_i);
  endtask

  // push the decoder back to idle by letting the current run overflow
  task automatic drain_decoder();
    while (sb.phase != PhIdle) begin
      send_level((sb.phase == PhLow) ? 1'b0 : 1'b1, 1'b0);
    end
    settle();
  endtask

  task automatic load_config(logic [7:0] edge_lim, logic [3:0] run_lim, logic [2:0] line);
    logic [7:0] vals [3];
    logic [7:0] junk;
    junk    = 8'($urandom);
    vals[0] = edge_lim;
    vals[1] = {junk[3:0], run_lim};
    vals[2] = {junk[7:3], line};
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index_i <= cfg_index_e'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(cfg_index_e'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) begin
      send_sample(8'($urandom), ($urandom_range(0, 15) == 0));
    end
  endtask

  task automatic send_frame(frame_kind_e kind);
    int          lim, cap, k, kmax, cut_at, break_at, lo, hi, sp;
    logic        first, break_low;
    logic [63:0] pat;
    lim = sb.edge_lim();
    cap = sb.run_cap();
    case ($urandom_range(0, 7))
      0:       pat = '1;
      1:       pat = '0;
      default: pat = {$urandom, $urandom};
    endcase
    kmax = (lim - 1 < 4) ? lim - 1 : 4;
    k = ($urandom_range(0, 9) == 0) ? lim - 1 : $urandom_range(0, kmax);
    if (kind == FrmLongSeek) k = lim;
    first = 1'b1;
    for (int i = 0; i < k; i++) begin
      send_level(1'b1, first);
      first = 1'b0;
    end
    if (kind == FrmLongSeek) return;
    cut_at    = (kind == FrmCut) ? $urandom_range(0, 63) : 64;
    break_at  = (kind == FrmLongRun) ? $urandom_range(0, 63) : -1;
    break_low = $urandom_range(0, 1);
    for (int i = 0; i < 64; i++) begin
      if (i == cut_at) return;
      // mostly short runs, now and then up to the cap
      sp = (cap < 3 || $urandom_range(0, 7) == 0) ? cap : 3;
      if (pat[i] || sp == 1) begin
        lo = $urandom_range(1, sp);
        hi = $urandom_range(lo, sp);
      end else begin
        lo = $urandom_range(2, sp);
        hi = $urandom_range(1, lo - 1);
      end
      if (i == break_at) begin
        if (break_low) lo = cap + 1;
        else hi = cap + 1;
      end
      for (int j = 0; j < lo; j++) begin
        send_level(1'b0, first);
        first = 1'b0;
      end
      if (i == break_at && break_low) return;
      for (int j = 0; j < hi; j++) send_level(1'b1, 1'b0);
      if (i == break_at) return;
    end
    send_level(1'b0, 1'b0);
  endtask

  initial begin : result_sink
    int      gap;
    result_t got;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 18);
      if (hold_off_req) begin
        hold_off_req = 0;
        gap = 600;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      got.buttons       = buttons_o;
      got.stick_x       = stick_x_o;
      got.stick_y       = stick_y_o;
      got.cstick_x      = cstick_x_o;
      got.cstick_y      = cstick_y_o;
      got.left_trigger  = left_trigger_o;
      got.right_trigger = right_trigger_o;
      got.frame_failed  = frame_failed_o;
      sb.check_report(got);
    end
  end

  initial begin : stimulus
    int          ph, nframes, r;
    logic [7:0]  e_opt;
    logic [3:0]  r_opt;
    sb = new;
    rst_ni        <= 1'b0;
    push          <= 1'b0;
    sample_byte_i <= '0;
    frame_start_i <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CfgEdgeSearchLimit;
    cfg_data_i    <= '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // idle: samples without a start are dropped
    send_sample(8'hFF, 1'b0);
    send_sample(8'h00, 1'b0);
    settle();
    load_config(8'd1, 4'd1, 3'd0);
    send_sample(8'hFF, 1'b1);
    send_sample(8'hFE, 1'b1);
    send_sample(8'h00, 1'b0);
    send_sample(8'h00, 1'b1);
    send_sample(8'hFF, 1'b0);
    send_sample(8'hFF, 1'b0);
    send_sample(8'h00, 1'b1);
    send_sample(8'hFF, 1'b0);
    send_sample(8'hFF, 1'b1);
    settle();
    load_config(8'd2, 4'd1, 3'd7);
    send_sample(8'h80, 1'b1);
    send_sample(8'h7F, 1'b0);
    send_sample(8'h80, 1'b0);
    send_sample(8'h01, 1'b0);
    send_sample(8'h7F, 1'b0);
    send_sample(8'h80, 1'b1);
    send_sample(8'h80, 1'b0);
    drain_decoder();

    // back-pressure: every high sample fails the frame at once
    load_config(8'd1, 4'd2, 3'($urandom_range(0, 7)));
    hold_off_req = 1;
    steady = 1;
    repeat (120) send_sample(8'($urandom), 1'b1);
    steady = 0;
    drain_decoder();

    ph = 0;
    while ((ph < 4 || n_samples < 1500) && ph < 64) begin
      case (ph % 4)
        0:       e_opt = 8'd1;
        1:       e_opt = 8'd255;
        2:       e_opt = 8'd0;
        default: e_opt = 8'($urandom_range(2, 40));
      endcase
      case (ph % 4)
        0:       r_opt = 4'd1;
        1:       r_opt = 4'd15;
        2:       r_opt = 4'd0;
        default: r_opt = 4'($urandom_range(1, 4));
      endcase
      if (ph == 0) load_config(EdgeSearchLimitRst, RunLimitRst, LineSelectRst);
      else load_config(e_opt, r_opt, 3'((ph * 3) % 8));
      steady = (ph % 3 == 1);
      nframes = (sb.run_cap() >= 8) ? 1 : 3;
      for (int f = 0; f < nframes; f++) begin
        r = $urandom_range(0, 9);
        if (r <= 5) send_frame(FrmGood);
        else if (r == 6) send_frame(FrmLongRun);
        else if (r == 7) send_frame(FrmLongSeek);
        else if (r == 8) send_frame(FrmCut);
        else begin
          send_noise();
          send_frame(FrmGood);
        end
      end
      steady = 0;
      drain_decoder();
      ph++;
    end

    settle();
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    $display("tb_top: %0d samples over %0d register settings", n_samples, n_settings);
    $display("tb_top: %0d frames decoded, %0d failed, input held off %0d cycles",
             sb.n_decoded, sb.n_failed, stall_cycles);
    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
